// File: rtl/core/itp_pkg.sv
package itp_pkg;

    // Operator and bracket characters
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // Error codes carried in a result
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_expr;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_last;
        logic [1:0] error_code;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_PASS,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_OPER,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
        logic [1:0] rank;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } back_state_t;

    function automatic logic [1:0] rank_of(input logic [7:0] ch);
        logic [1:0] r;
        unique case (ch) inside
            CH_CARET:           r = 2'd3;
            CH_STAR, CH_SLASH:  r = 2'd2;
            CH_PLUS, CH_MINUS:  r = 2'd1;
            default:            r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/itp_front.sv
module itp_front
    import itp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     q_wvalid,
    input  logic     q_wready,
    output cmd_t     q_wcmd
);

    logic f_valid_reg;
    logic f_valid_next;
    cmd_t f_cmd_reg;
    cmd_t f_cmd_next;
    logic accept;

    function automatic logic is_alnum(input logic [7:0] ch);
        return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
               (ch >= 8'h61 && ch <= 8'h7A);
    endfunction

    assign s_ready  = !f_valid_reg || q_wready;
    assign accept   = s_valid && s_ready;
    assign q_wvalid = f_valid_reg;
    assign q_wcmd   = f_cmd_reg;

    // Classify the request into a stack command
    always_comb begin
        f_cmd_next.ch   = s_item.in_char;
        f_cmd_next.rank = rank_of(s_item.in_char);
        if (s_item.end_of_expr) begin
            f_cmd_next.kind = CMD_END;
        end else if (is_alnum(s_item.in_char)) begin
            f_cmd_next.kind = CMD_PASS;
        end else if (s_item.in_char == CH_LPAREN) begin
            f_cmd_next.kind = CMD_OPEN;
        end else if (s_item.in_char == CH_RPAREN) begin
            f_cmd_next.kind = CMD_CLOSE;
        end else begin
            f_cmd_next.kind = CMD_OPER;
        end
    end

    always_comb begin
        if (accept) begin
            f_valid_next = 1'b1;
        end else if (q_wready) begin
            f_valid_next = 1'b0;
        end else begin
            f_valid_next = f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f_cmd_reg <= f_cmd_next;
        end
    end

endmodule

// File: rtl/core/itp_cmd_queue.sv
module itp_cmd_queue
    import itp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wvalid,
    output logic wready,
    input  cmd_t wcmd,
    output logic rvalid,
    input  logic rready,
    output cmd_t rcmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] wptr_next;
    logic [PW-1:0] rptr_reg;
    logic [PW-1:0] rptr_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          do_write;
    logic          do_read;

    assign wready   = fill_reg != CW'(QUEUE_DEPTH);
    assign rvalid   = fill_reg != '0;
    assign rcmd     = entry_reg[rptr_reg];
    assign do_write = wvalid && wready;
    assign do_read  = rvalid && rready;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (do_write) begin
            wptr_next = (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_read) begin
            rptr_next = (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        case ({do_write, do_read})
            2'b10:   fill_next = fill_reg + CW'(1);
            2'b01:   fill_next = fill_reg - CW'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            entry_reg[wptr_reg] <= wcmd;
        end
    end

endmodule

// File: rtl/core/itp_back.sv
module itp_back
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  cmd_t      q_cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]    stack_mem [STACK_DEPTH];
    logic [7:0]    top_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    back_state_t   state_reg;
    back_state_t   state_next;
    cmd_t          cmd_reg;
    cmd_t          cmd_next;

    logic          m_valid_reg;
    logic          m_valid_next;
    out_item_t     m_item_reg;
    out_item_t     m_item_next;
    out_item_t     out_next;
    logic          load_out;
    logic          out_free;
    logic          done;
    logic          full;
    logic          empty;

    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = count_reg == CW'(STACK_DEPTH);
    assign empty    = count_reg == '0;
    assign wr_addr  = count_reg[AW-1:0];
    assign count_m1 = count_next - CW'(1);
    assign rd_addr  = count_m1[AW-1:0];

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        load_out   = 1'b0;
        out_next   = '{out_char: 8'd0, is_last: 1'b0, error_code: ERR_NONE};
        done       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                done = 1'b1;
            end
            ST_EXEC: begin
                unique case (cmd_reg.kind)
                    CMD_PASS: begin
                        if (out_free) begin
                            load_out          = 1'b1;
                            out_next.out_char = cmd_reg.ch;
                            done              = 1'b1;
                        end
                    end
                    CMD_OPEN: begin
                        if (full) begin
                            if (out_free) begin
                                load_out            = 1'b1;
                                out_next.is_last    = 1'b1;
                                out_next.error_code = ERR_OVERFLOW;
                                count_next          = '0;
                                done                = 1'b1;
                            end
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                            done       = 1'b1;
                        end
                    end
                    CMD_CLOSE: begin
                        if (empty) begin
                            if (out_free) begin
                                load_out            = 1'b1;
                                out_next.is_last    = 1'b1;
                                out_next.error_code = ERR_UNMATCHED;
                                done                = 1'b1;
                            end
                        end else if (top_reg == CH_LPAREN) begin
                            count_next = count_reg - CW'(1);
                            done       = 1'b1;
                        end else if (out_free) begin
                            load_out          = 1'b1;
                            out_next.out_char = top_reg;
                            count_next        = count_reg - CW'(1);
                        end
                    end
                    CMD_OPER: begin
                        if (!empty && rank_of(top_reg) >= cmd_reg.rank) begin
                            if (out_free) begin
                                load_out          = 1'b1;
                                out_next.out_char = top_reg;
                                count_next        = count_reg - CW'(1);
                            end
                        end else if (full) begin
                            if (out_free) begin
                                load_out            = 1'b1;
                                out_next.is_last    = 1'b1;
                                out_next.error_code = ERR_OVERFLOW;
                                count_next          = '0;
                                done                = 1'b1;
                            end
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                            done       = 1'b1;
                        end
                    end
                    CMD_END: begin
                        if (out_free) begin
                            load_out = 1'b1;
                            if (!empty) begin
                                out_next.out_char = top_reg;
                                count_next        = count_reg - CW'(1);
                            end else begin
                                out_next.is_last = 1'b1;
                                done             = 1'b1;
                            end
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            default: begin
                done = 1'b1;
            end
        endcase

        // Take the next command as soon as the current one retires
        q_ready = done;
        if (done) begin
            if (q_valid) begin
                cmd_next   = q_cmd;
                state_next = ST_EXEC;
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    always_comb begin
        m_item_next = m_item_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_item_next  = out_next;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_item_reg <= m_item_next;
    end

    // Stack memory; the read port keeps the top entry registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= cmd_reg.ch;
        end
        if (wr_en && wr_addr == rd_addr) begin
            top_reg <= cmd_reg.ch;
        end else begin
            top_reg <= stack_mem[rd_addr];
        end
    end

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !full)
        else $error("push into full stack");

    a_last_empties_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && out_next.is_last) |=> (count_reg == '0))
        else $error("stack not empty after closing result");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_item_reg.error_code != ERR_NONE) |->
            (m_item_reg.is_last && m_item_reg.out_char == 8'd0))
        else $error("error result not marked last");

endmodule

// File: rtl/core/infix_to_postfix_converter.sv
// Channel   Direction  Payload     Handshake
// s_        in         in_item_t   s_valid / s_ready
// m_        out        out_item_t  m_valid / m_ready
//
// A letter or digit request passes through the front register, the command queue, the
// back command register and the output register; steady state is one command per cycle
// while the output is not stalled and no command pops the stack. A popping request emits
// one stacked entry at a time; an end request drains the stack, then emits its last item.
// Reset (aresetn, synchronous, active low) empties the stack, queue and output register.
// A stalled m_ready holds the back stage; the front keeps accepting until the queue fills.
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // Classified commands from the front toward the queue
    logic q_wvalid;
    logic q_wready;
    cmd_t q_wcmd;

    // Commands from the queue toward the back stage
    logic q_rvalid;
    logic q_rready;
    cmd_t q_rcmd;

    // Front: accept each request and decode it into a stack command
    itp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .q_wvalid (q_wvalid),
        .q_wready (q_wready),
        .q_wcmd   (q_wcmd)
    );

    // Short queue: decouple the front from pops stalled on the output
    itp_cmd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wvalid  (q_wvalid),
        .wready  (q_wready),
        .wcmd    (q_wcmd),
        .rvalid  (q_rvalid),
        .rready  (q_rready),
        .rcmd    (q_rcmd)
    );

    // Back: run the operator stack and drive the output register
    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_rvalid),
        .q_ready (q_rready),
        .q_cmd   (q_rcmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
